@@ rtl/ccst_pkg.sv @@
// shared types, command codes and calendar helper functions
// for the seconds-tick real-time clock calendar; no dependencies
package ccst_pkg;

  localparam int unsigned SecW   = 6;
  localparam int unsigned MinW   = 6;
  localparam int unsigned HourW  = 5;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 16;
  localparam int unsigned TimeW  = SecW + MinW + HourW + DayW + MonW + YearW;
  localparam int unsigned DataW  = ((TimeW + 7) / 8) * 8;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned FlagW  = 2;

  localparam logic [SecW-1:0]  SecLast   = 6'd59;
  localparam logic [MinW-1:0]  MinLast   = 6'd59;
  localparam logic [HourW-1:0] HourLast  = 5'd23;
  localparam logic [MonW-1:0]  MonFirst  = 4'd1;
  localparam logic [MonW-1:0]  MonLast   = 4'd12;
  localparam logic [MonW-1:0]  MonFeb    = 4'd2;
  localparam logic [DayW-1:0]  DayFirst  = 5'd1;
  localparam logic [DayW-1:0]  DayLeapFeb = 5'd29;
  localparam logic [YearW-1:0] YearReset = 16'd2000;

  // floor(y / 25) = (y * Div25Mul) >> Div25Shift for any 16-bit y
  localparam int unsigned Div25Shift = 21;
  localparam logic [37:0] Div25Mul   = 38'd83887;

  typedef enum logic [CmdW-1:0] {
    CmdTick = 2'd0,
    CmdDay  = 2'd1,
    CmdLoad = 2'd2
  } ccst_cmd_e;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [MonW-1:0]  month;
    logic [DayW-1:0]  day;
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
  } ccst_time_t;

  typedef struct packed {
    ccst_cmd_e  cmd;
    ccst_time_t set;
  } ccst_item_t;

  typedef struct packed {
    logic load_error;
    logic day_rolled;
  } ccst_flags_t;

  function automatic logic div_by_25(input logic [YearW-1:0] y);
    logic [37:0]      prod;
    logic [11:0]      q;
    logic [YearW-1:0] back;
    prod = {22'd0, y} * Div25Mul;
    q    = prod[Div25Shift+11:Div25Shift];
    back = {q, 4'b0000} + 16'({q, 3'b000}) + 16'(q);
    return back == y;
  endfunction

  // gregorian rule: by 400, or by 4 and not by 100
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic d25;
    d25 = div_by_25(y);
    return ((y[3:0] == 4'd0) && d25) || ((y[1:0] == 2'd0) && !d25);
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m);
    logic [DayW-1:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                      n = 5'd30;
      4'd2:                                         n = 5'd28;
      default:                                      n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [DayW-1:0] days_in(input logic [MonW-1:0] m,
                                              input logic [YearW-1:0] y);
    logic [DayW-1:0] n;
    n = month_len(m);
    if (m == MonFeb && is_leap(y)) begin
      n = DayLeapFeb;
    end
    return n;
  endfunction

endpackage

@@ rtl/ccst_in_reg.sv @@
// input register stage: holds one accepted command until the step logic takes it
// depends on ccst_pkg
module ccst_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  input  ccst_pkg::ccst_item_t s_item_i,
  input  logic                 take_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output ccst_pkg::ccst_item_t item_o
);
  import ccst_pkg::*;

  logic       valid_q;
  ccst_item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && s_valid_i) begin
      item_q <= s_item_i;
    end
  end

endmodule

@@ rtl/ccst_calc.sv @@
// next-state logic: second tick cascade, day advance and checked load
// depends on ccst_pkg
module ccst_calc (
  input  ccst_pkg::ccst_time_t  cur_i,
  input  ccst_pkg::ccst_item_t  item_i,
  output ccst_pkg::ccst_time_t  nxt_o,
  output ccst_pkg::ccst_flags_t flags_o
);
  import ccst_pkg::*;

  logic [DayW-1:0]  max_day;
  logic [DayW-1:0]  set_max_day;
  logic             day_wrap;
  logic [DayW-1:0]  adv_day;
  logic [MonW-1:0]  adv_month;
  logic [YearW-1:0] adv_year;
  logic             load_ok;

  always_comb begin
    max_day  = days_in(cur_i.month, cur_i.year);
    day_wrap = cur_i.day >= max_day;
    if (!day_wrap) begin
      adv_day   = cur_i.day + 5'd1;
      adv_month = cur_i.month;
      adv_year  = cur_i.year;
    end else if (cur_i.month >= MonLast) begin
      adv_day   = DayFirst;
      adv_month = MonFirst;
      adv_year  = cur_i.year + 16'd1;
    end else begin
      adv_day   = DayFirst;
      adv_month = cur_i.month + 4'd1;
      adv_year  = cur_i.year;
    end
  end

  always_comb begin
    set_max_day = days_in(item_i.set.month, item_i.set.year);
    load_ok = (item_i.set.month >= MonFirst) && (item_i.set.month <= MonLast) &&
              (item_i.set.day >= DayFirst) && (item_i.set.day <= set_max_day) &&
              (item_i.set.second <= SecLast) && (item_i.set.minute <= MinLast) &&
              (item_i.set.hour <= HourLast);
  end

  always_comb begin
    nxt_o   = cur_i;
    flags_o = '0;
    unique case (item_i.cmd)
      CmdTick: begin
        if (cur_i.second < SecLast) begin
          nxt_o.second = cur_i.second + 6'd1;
        end else begin
          nxt_o.second = '0;
          if (cur_i.minute < MinLast) begin
            nxt_o.minute = cur_i.minute + 6'd1;
          end else begin
            nxt_o.minute = '0;
            if (cur_i.hour < HourLast) begin
              nxt_o.hour = cur_i.hour + 5'd1;
            end else begin
              nxt_o.hour          = '0;
              nxt_o.day           = adv_day;
              nxt_o.month         = adv_month;
              nxt_o.year          = adv_year;
              flags_o.day_rolled  = day_wrap;
            end
          end
        end
      end
      CmdDay: begin
        nxt_o.day          = adv_day;
        nxt_o.month        = adv_month;
        nxt_o.year         = adv_year;
        flags_o.day_rolled = day_wrap;
      end
      CmdLoad: begin
        if (load_ok) begin
          nxt_o = item_i.set;
        end else begin
          flags_o.load_error = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/calendar_clock_seconds_tick.sv @@
// top level of the seconds-tick gregorian real-time clock calendar
// depends on ccst_pkg, ccst_in_reg and ccst_calc
//
//  port group   dir  tdata (low bit up)                        tuser
//  s_axis       in   second minute hour day month year        cmd
//  m_axis       out  second minute hour day month year        day_rolled load_error
//
// one command per cycle if m_axis is free; it goes via input and result registers
// the date and time registers update in the same cycle as the result register,
// so back-to-back commands see each other without stall
// reset gives 00:00:00 on day 1 of month 1, year 2000, with no clearing pass
// a stalled output holds its result; the input register still takes one more command
module calendar_clock_seconds_tick (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // second, minute, hour, day, month, year, zero pad
  input  logic [ccst_pkg::DataW-1:0] s_axis_tdata_i,
  // cmd
  input  logic [ccst_pkg::CmdW-1:0]  s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // second, minute, hour, day, month, year, zero pad
  output logic [ccst_pkg::DataW-1:0] m_axis_tdata_o,
  // day_rolled, load_error
  output logic [ccst_pkg::FlagW-1:0] m_axis_tuser_o
);
  import ccst_pkg::*;

  ccst_item_t  s_item;
  ccst_item_t  cur_item;
  logic        cur_valid;
  logic        advance;
  ccst_time_t  state_q;
  ccst_time_t  state_d;
  ccst_flags_t flags_d;
  ccst_time_t  res_time_q;
  ccst_flags_t res_flags_q;
  logic        out_valid_q;

  assign s_item.cmd = ccst_cmd_e'(s_axis_tuser_i);
  assign s_item.set = ccst_time_t'(s_axis_tdata_i[TimeW-1:0]);

  assign advance = cur_valid && (!out_valid_q || m_axis_tready_i);

  ccst_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_item_i  (s_item),
    .take_i    (advance),
    .ready_o   (s_axis_tready_o),
    .valid_o   (cur_valid),
    .item_o    (cur_item)
  );

  ccst_calc u_calc (
    .cur_i   (state_q),
    .item_i  (cur_item),
    .nxt_o   (state_d),
    .flags_o (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{year: YearReset, month: MonFirst, day: DayFirst,
                   hour: '0, minute: '0, second: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_time_q  <= state_d;
      res_flags_q <= flags_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(DataW - TimeW)'(0), res_time_q};
  assign m_axis_tuser_o  = res_flags_q;

  // time and month registers stay in range, and the day is at least one
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.second <= SecLast) && (state_q.minute <= MinLast) &&
    (state_q.hour <= HourLast) && (state_q.month >= MonFirst) &&
    (state_q.month <= MonLast) && (state_q.day >= DayFirst))
    else $error("clock state out of range");

  // a rejected load leaves the clock as it was
  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && flags_d.load_error |=> state_q == $past(state_q))
    else $error("rejected load changed the clock");

  // a month roll always lands on the first day
  a_roll_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res_flags_q.day_rolled |-> res_time_q.day == DayFirst)
    else $error("day roll without day one");

  // both flags never show together
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(res_flags_q.day_rolled && res_flags_q.load_error))
    else $error("roll and load error together");

endmodule
